FILE: hw/rtl/sbbpd_pkg.sv
// Package for the byte bit-permute decoder: state type, control structs,
// the bit shift table, the group permutations and their helper functions.
// No dependencies.
`timescale 1ns / 1ps

package sbbpd_pkg;

    localparam logic [7:0] XOR_KEY       = 8'hF0;
    localparam logic [7:0] READABLE_BYTE = 8'hFF;
    localparam logic [2:0] HDR_LEN       = 3'd4;

    localparam logic [7:0] TYPE_PAIR = 8'd0;
    localparam logic [7:0] TYPE_QUAD = 8'd1;
    localparam logic [7:0] TYPE_OCT  = 8'd2;

    typedef enum logic [0:0] {
        S_COLLECT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic take;   // an input transaction completes this cycle
        logic emit;   // load the next buffered byte into the output register
    } t_cmd;

    typedef struct packed {
        logic in_hdr;      // the next input byte belongs to the header
        logic grp_done;    // the offered body byte completes a group or the file
        logic out_free;    // the output register can take a byte this cycle
        logic emit_final;  // the current emit index is the last of the group
    } t_status;

    localparam logic signed [3:0] SHIFT_ROWS [8][8] = '{
        '{ 4'sd2,  4'sd6, -4'sd1,  4'sd0,  4'sd1, -4'sd5, -4'sd2, -4'sd1 },
        '{ 4'sd3,  4'sd4,  4'sd0,  4'sd3, -4'sd3,  4'sd2, -4'sd6, -4'sd3 },
        '{ 4'sd7,  4'sd5,  4'sd3,  4'sd1, -4'sd1, -4'sd3, -4'sd5, -4'sd7 },
        '{ 4'sd3,  4'sd1, -4'sd1, -4'sd3,  4'sd3,  4'sd1, -4'sd1, -4'sd3 },
        '{ 4'sd6,  4'sd3, -4'sd2,  4'sd4, -4'sd3, -4'sd2, -4'sd1, -4'sd5 },
        '{ 4'sd5,  4'sd6,  4'sd4, -4'sd1, -4'sd4, -4'sd4, -4'sd2, -4'sd4 },
        '{ 4'sd7, -4'sd1,  4'sd4, -4'sd2, -4'sd2, -4'sd1, -4'sd3, -4'sd2 },
        '{ 4'sd1,  4'sd5, -4'sd2, -4'sd1,  4'sd1,  4'sd2, -4'sd2, -4'sd4 }
    };

    localparam logic [2:0] PERM2 [2] = '{ 3'd1, 3'd0 };
    localparam logic [2:0] PERM4 [4] = '{ 3'd2, 3'd3, 3'd0, 3'd1 };
    localparam logic [2:0] PERM8 [8] = '{ 3'd6, 3'd4, 3'd5, 3'd7, 3'd1, 3'd2, 3'd0, 3'd3 };

    function automatic logic [3:0] group_size(input logic [7:0] gtype);
        logic [3:0] s;
        case (gtype)
            TYPE_PAIR: s = 4'd2;
            TYPE_QUAD: s = 4'd4;
            TYPE_OCT:  s = 4'd8;
            default:   s = 4'd1;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] perm_src(input logic [7:0] gtype, input logic [2:0] k);
        logic [2:0] s;
        case (gtype)
            TYPE_PAIR: s = PERM2[k[0]];
            TYPE_QUAD: s = PERM4[k[1:0]];
            TYPE_OCT:  s = PERM8[k];
            default:   s = 3'd0;
        endcase
        return s;
    endfunction

    // For keys under 8 each bit moves by the signed shift of its column;
    // bits pushed past either end drop, then the whole byte is inverted.
    function automatic logic [7:0] bit_step(input logic [7:0] key, input logic [7:0] b);
        logic [7:0]        acc;
        logic signed [4:0] dest;
        acc = 8'd0;
        for (int i = 0; i < 8; i++) begin
            dest = 5'(signed'({2'b00, 3'(i)})) + 5'(SHIFT_ROWS[key[2:0]][i]);
            if (b[i] && dest >= 5'sd0 && dest <= 5'sd7) begin
                acc = acc | (8'd1 << dest[2:0]);
            end
        end
        return (key >= 8'd8) ? b : ~acc;
    endfunction

endpackage

FILE: hw/rtl/sbbpd_if.sv
// Handshake channel interfaces for the decoder: input bytes, output bytes
// and the configuration write channel. No dependencies.
`timescale 1ns / 1ps

interface sbbpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sbbpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface sbbpd_cfg_if;
    logic valid;
    logic ready;
    logic make_readable;
    modport source (output valid, output make_readable, input ready);
    modport sink   (input valid, input make_readable, output ready);
endinterface

FILE: hw/rtl/sbbpd_ctrl.sv
// Controller for the decoder: alternates between collecting input bytes
// and draining a finished group. Depends on sbbpd_pkg.
`timescale 1ns / 1ps

module sbbpd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sbbpd_pkg::t_status i_status,
    output sbbpd_pkg::t_cmd  o_cmd
);
    import sbbpd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_COLLECT: begin
                if (o_cmd.take && !i_status.in_hdr && i_status.grp_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_cmd.emit && i_status.emit_final) begin
                    n_state = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.take = 1'b0;
        o_cmd.emit = 1'b0;
        case (r_state)
            S_COLLECT: begin
                o_in_ready = i_status.out_free;
                o_cmd.take = i_in_valid && i_status.out_free;
            end
            S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_take_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !o_cmd.take)
        else $error("input accepted while a group is draining");
    a_emit_ends_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_status.emit_final) |=> (r_state == S_COLLECT))
        else $error("controller did not return to collecting after a group");
    a_group_enters_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && !i_status.in_hdr && i_status.grp_done) |=> (r_state == S_EMIT))
        else $error("completed group did not start draining");
`endif

endmodule

FILE: hw/rtl/sbbpd_dp.sv
// Datapath for the decoder: header state, group buffer, emit counters,
// bit permutation and the output register. Depends on sbbpd_pkg.
`timescale 1ns / 1ps

module sbbpd_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbbpd_pkg::t_cmd    i_cmd,
    output sbbpd_pkg::t_status o_status,
    input  logic [7:0]         i_in_byte,
    input  logic               i_in_last,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_make_readable,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_out_last
);
    import sbbpd_pkg::*;

    logic       r_make_readable;
    logic [2:0] r_hdr_pos,  n_hdr_pos;
    logic [7:0] r_key_row,  n_key_row;
    logic [7:0] r_gtype,    n_gtype;
    logic [3:0] r_fill,     n_fill;
    logic [7:0] r_buf [8];
    logic [2:0] r_emit_idx, n_emit_idx;
    logic [3:0] r_emit_n,   n_emit_n;
    logic       r_emit_perm, n_emit_perm;
    logic       r_emit_last, n_emit_last;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte,  n_out_byte;
    logic       r_out_last,  n_out_last;

    logic       in_hdr;
    logic [3:0] size;
    logic [3:0] fill_inc;
    logic       emit_final;
    logic [2:0] src;

    assign in_hdr     = (r_hdr_pos < HDR_LEN);
    assign size       = group_size(r_gtype);
    assign fill_inc   = r_fill + 4'd1;
    assign emit_final = ({1'b0, r_emit_idx} == (r_emit_n - 4'd1));
    assign src        = r_emit_perm ? perm_src(r_gtype, r_emit_idx) : r_emit_idx;

    assign o_status.in_hdr     = in_hdr;
    assign o_status.grp_done   = (fill_inc >= size) || i_in_last;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.emit_final = emit_final;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    always_comb begin
        n_hdr_pos   = r_hdr_pos;
        n_key_row   = r_key_row;
        n_gtype     = r_gtype;
        n_fill      = r_fill;
        n_emit_idx  = r_emit_idx;
        n_emit_n    = r_emit_n;
        n_emit_perm = r_emit_perm;
        n_emit_last = r_emit_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (i_cmd.take && in_hdr) begin
            if (r_hdr_pos == 3'd0) begin
                n_key_row = i_in_byte ^ XOR_KEY;
            end else if (r_hdr_pos == 3'd1) begin
                n_gtype = i_in_byte ^ XOR_KEY;
            end
            n_hdr_pos   = r_hdr_pos + 3'd1;
            n_out_valid = 1'b1;
            n_out_byte  = (r_hdr_pos < 3'd2 && r_make_readable) ? READABLE_BYTE : i_in_byte;
            n_out_last  = i_in_last;
            if (i_in_last) begin
                n_hdr_pos = 3'd0;
                n_key_row = 8'd0;
                n_gtype   = 8'd0;
                n_fill    = 4'd0;
            end
        end else if (i_cmd.take) begin
            n_emit_idx = 3'd0;
            if (fill_inc >= size) begin
                n_emit_n    = size;
                n_emit_perm = (size != 4'd1);
                n_emit_last = i_in_last;
                n_fill      = 4'd0;
            end else if (i_in_last) begin
                // A trailing partial group drains in arrival order.
                n_emit_n    = fill_inc;
                n_emit_perm = 1'b0;
                n_emit_last = 1'b1;
                n_fill      = 4'd0;
            end else begin
                n_fill = fill_inc;
            end
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = bit_step(r_key_row, r_buf[src]);
            n_out_last  = r_emit_last && emit_final;
            n_emit_idx  = r_emit_idx + 3'd1;
            // The key row is still needed until the last byte of the file leaves.
            if (emit_final && r_emit_last) begin
                n_hdr_pos = 3'd0;
                n_key_row = 8'd0;
                n_gtype   = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_make_readable <= 1'b0;
            r_hdr_pos       <= 3'd0;
            r_key_row       <= 8'd0;
            r_gtype         <= 8'd0;
            r_fill          <= 4'd0;
            r_emit_idx      <= 3'd0;
            r_emit_n        <= 4'd0;
            r_emit_perm     <= 1'b0;
            r_emit_last     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_make_readable <= i_cfg_make_readable;
            end
            r_hdr_pos   <= n_hdr_pos;
            r_key_row   <= n_key_row;
            r_gtype     <= n_gtype;
            r_fill      <= n_fill;
            r_emit_idx  <= n_emit_idx;
            r_emit_n    <= n_emit_n;
            r_emit_perm <= n_emit_perm;
            r_emit_last <= n_emit_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        if (i_cmd.take && !in_hdr) begin
            r_buf[r_fill[2:0]] <= i_in_byte;
        end
    end

`ifndef SYNTHESIS
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (({1'b0, r_emit_idx} < r_emit_n) && (r_emit_n <= size)))
        else $error("emit index beyond the group being drained");
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < 4'd8)
        else $error("group fill count out of range");
    a_file_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && emit_final && r_emit_last) |=> (r_hdr_pos == 3'd0 && r_fill == 4'd0))
        else $error("header state not cleared after the final byte");
`endif

endmodule

FILE: hw/rtl/script_byte_bit_permute_decoder.sv
// Timing: a header byte is presented in the cycle after its transaction; a body
// group's first byte passes the emit state and then the output register once the
// transaction that completes it is taken. Header bytes go one per cycle while the
// output accepts; a body group is collected, then drained while input is held off.
// Reset (synchronous, active low) clears header, fill and emit control and the
// readable option; the group buffer and output payload are not reset.
`timescale 1ns / 1ps

module script_byte_bit_permute_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbbpd_in_if.sink   i_in_ch,
    sbbpd_out_if.source o_out_ch,
    sbbpd_cfg_if.sink  i_cfg_ch
);
    import sbbpd_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_in_ch.ready  = in_ready;
    assign i_cfg_ch.ready = 1'b1;

    sbbpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sbbpd_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_in_byte           (i_in_ch.in_byte),
        .i_in_last           (i_in_ch.in_last),
        .i_cfg_valid         (i_cfg_ch.valid),
        .i_cfg_make_readable (i_cfg_ch.make_readable),
        .i_out_ready         (o_out_ch.ready),
        .o_out_valid         (o_out_ch.valid),
        .o_out_byte          (o_out_ch.out_byte),
        .o_out_last          (o_out_ch.out_last)
    );

endmodule

FILE: dv/tb.sv
// Testbench for script_byte_bit_permute_decoder: drives byte files with random idling,
// predicts every decoded byte and checks it in order. Depends on sbbpd_pkg and the
// channel interfaces in sbbpd_if.sv.
`timescale 1ns / 1ps

module tb;
    import sbbpd_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;

    // Signed bit moves per key row, one column per source bit.
    localparam int MOVE_TAB [8][8] = '{
        '{ 2,  6, -1,  0,  1, -5, -2, -1 },
        '{ 3,  4,  0,  3, -3,  2, -6, -3 },
        '{ 7,  5,  3,  1, -1, -3, -5, -7 },
        '{ 3,  1, -1, -3,  3,  1, -1, -3 },
        '{ 6,  3, -2,  4, -3, -2, -1, -5 },
        '{ 5,  6,  4, -1, -4, -4, -2, -4 },
        '{ 7, -1,  4, -2, -2, -1, -3, -2 },
        '{ 1,  5, -2, -1,  1,  2, -2, -4 }
    };
    localparam int ORDER2 [2] = '{ 1, 0 };
    localparam int ORDER4 [4] = '{ 2, 3, 0, 1 };
    localparam int ORDER8 [8] = '{ 6, 4, 5, 7, 1, 2, 0, 3 };

    typedef struct {
        logic [7:0] data;
        logic       is_last;
    } t_decoded;

    function automatic logic [7:0] scramble_bits(input logic [7:0] key, input logic [7:0] b);
        logic [7:0] acc;
        int         dest;
        if (key >= 8'd8) begin
            return b;
        end
        acc = 8'd0;
        for (int i = 0; i < 8; i++) begin
            dest = i + MOVE_TAB[key[2:0]][i];
            if (b[i] && dest >= 0 && dest <= 7) begin
                acc[dest] = 1'b1;
            end
        end
        return ~acc;
    endfunction

    function automatic int group_span(input logic [7:0] gtype);
        case (gtype)
            TYPE_PAIR: return 2;
            TYPE_QUAD: return 4;
            TYPE_OCT:  return 8;
            default:   return 1;
        endcase
    endfunction

    function automatic int reorder_src(input logic [7:0] gtype, input int k);
        case (gtype)
            TYPE_PAIR: return ORDER2[k];
            TYPE_QUAD: return ORDER4[k];
            TYPE_OCT:  return ORDER8[k];
            default:   return 0;
        endcase
    endfunction

    class decode_scoreboard;
        logic       readable;
        logic [2:0] hdr_pos;
        logic [7:0] key_row;
        logic [7:0] grp_type;
        logic [7:0] grp_bytes [8];
        int         fill;
        t_decoded   expected_q [$];
        int         errors;
        int         n_in;
        int         n_out;

        function new();
            readable = 1'b0;
            errors   = 0;
            n_in     = 0;
            n_out    = 0;
            clear_file();
        endfunction

        function void clear_file();
            hdr_pos  = 3'd0;
            key_row  = 8'd0;
            grp_type = 8'd0;
            fill     = 0;
        endfunction

        function void set_readable(input logic v);
            readable = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(input logic [7:0] b, input logic is_last);
            logic [7:0] batch [$];
            logic [7:0] o;
            t_decoded   d;
            int         span;
            n_in++;
            if (hdr_pos < HDR_LEN) begin
                o = b;
                if (hdr_pos == 3'd0) begin
                    key_row = b ^ XOR_KEY;
                end else if (hdr_pos == 3'd1) begin
                    grp_type = b ^ XOR_KEY;
                end
                if (hdr_pos < 3'd2 && readable) begin
                    o = READABLE_BYTE;
                end
                hdr_pos++;
                batch.push_back(o);
            end else begin
                span = group_span(grp_type);
                grp_bytes[fill] = b;
                fill++;
                if (fill >= span) begin
                    for (int k = 0; k < span; k++) begin
                        batch.push_back(scramble_bits(key_row, grp_bytes[reorder_src(grp_type, k)]));
                    end
                    fill = 0;
                end else if (is_last) begin
                    // A short trailing group keeps its arrival order.
                    for (int k = 0; k < fill; k++) begin
                        batch.push_back(scramble_bits(key_row, grp_bytes[k]));
                    end
                    fill = 0;
                end
            end
            for (int k = 0; k < batch.size(); k++) begin
                d.data    = batch[k];
                d.is_last = is_last && (k == batch.size() - 1);
                expected_q.push_back(d);
            end
            if (is_last) begin
                clear_file();
            end
        endfunction

        function void check_output(input logic [7:0] b, input logic is_last);
            t_decoded d;
            n_out++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected output: expected none, got byte %02h last %0b",
                         $time, b, is_last);
                errors++;
                return;
            end
            d = expected_q.pop_front();
            if (b !== d.data) begin
                $display("%0t: out_byte mismatch: expected %02h, got %02h", $time, d.data, b);
                errors++;
            end
            if (is_last !== d.is_last) begin
                $display("%0t: out_last mismatch: expected %0b, got %0b",
                         $time, d.is_last, is_last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle;
    int   recv_idle;
    int   stall_cycles;
    int   files;
    decode_scoreboard sb;

    sbbpd_in_if  in_ch ();
    sbbpd_out_if out_ch ();
    sbbpd_cfg_if cfg_ch ();

    script_byte_bit_permute_decoder i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    always #6 clk = ~clk;

    always @(negedge clk) begin
        out_ch.ready = ($urandom_range(99) >= recv_idle);
    end

    // Every transaction is taken at the rising edge; the watchdog counts edges without one.
    always @(posedge clk) begin
        if (in_ch.valid && in_ch.ready) begin
            sb.note_input(in_ch.in_byte, in_ch.in_last);
        end
        if (out_ch.valid && out_ch.ready) begin
            sb.check_output(out_ch.out_byte, out_ch.out_last);
        end
        if (cfg_ch.valid && cfg_ch.ready) begin
            sb.set_readable(cfg_ch.make_readable);
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, sb.pending());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.in_byte = b;
        in_ch.in_last = is_last;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Holds the input off until every expected byte is out and the block has gone quiet.
    task automatic settle();
        in_ch.valid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_readable(input logic v);
        cfg_ch.valid         = 1'b1;
        cfg_ch.make_readable = v;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic random_files(input int count);
        int         sent;
        int         total;
        logic [7:0] key_byte;
        logic [7:0] type_byte;
        logic [7:0] b;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                total = $urandom_range(4, 1);
            end else if ($urandom_range(3) == 0) begin
                total = 4 + $urandom_range(24, 9);
            end else begin
                total = 4 + $urandom_range(8, 1);
            end
            if ($urandom_range(9) < 7) begin
                key_byte = 8'($urandom_range(7)) ^ XOR_KEY;
            end else begin
                key_byte = 8'($urandom_range(255));
            end
            if ($urandom_range(9) < 8) begin
                type_byte = 8'($urandom_range(2)) ^ XOR_KEY;
            end else begin
                type_byte = 8'($urandom_range(255));
            end
            for (int i = 0; i < total; i++) begin
                if (i == 0) begin
                    b = key_byte;
                end else if (i == 1) begin
                    b = type_byte;
                end else begin
                    b = 8'($urandom_range(255));
                end
                send_byte(b, i == total - 1);
            end
            sent += total;
            files++;
            if ($urandom_range(19) == 0) begin
                settle();
            end
        end
    endtask

    initial begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        send_idle            = 0;
        recv_idle            = 0;
        stall_cycles         = 0;
        files                = 0;
        in_ch.valid          = 1'b0;
        in_ch.in_byte        = 8'd0;
        in_ch.in_last        = 1'b0;
        out_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.make_readable = 1'b0;
        sb                   = new();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        write_readable(1'b1);
        // A file that ends on its first header byte.
        send_byte(8'h0F, 1'b1);
        // Pairs with key row 0, one full pair and a single trailing byte.
        send_byte(8'hF0, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        // Quads with key row 2, one group closed by the final byte.
        send_byte(8'hF2, 1'b0);
        send_byte(8'hF1, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h80, 1'b1);
        // Octets with key row 8, so no bit step; three bytes of a group left over.
        send_byte(8'hF8, 1'b0);
        send_byte(8'hF2, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b1);
        // Unknown group type with key row 7: the body byte is decoded as a group of one.
        send_byte(8'hF7, 1'b0);
        send_byte(8'hC7, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hE1, 1'b0);
        send_byte(8'hFF, 1'b1);
        files = 5;
        settle();

        write_readable(1'b0);
        send_idle = 13;
        recv_idle = 75;
        random_files(64);
        settle();

        write_readable(1'b1);
        send_idle = 75;
        recv_idle = 13;
        random_files(64);
        settle();

        write_readable(1'b0);
        send_idle = 0;
        recv_idle = 0;
        random_files(64);
        settle();

        $display("summary: %0d files, %0d bytes in, %0d bytes out, %0d errors",
                 files, sb.n_in, sb.n_out, sb.errors);
        $display("summary: all group types, short files and trailing groups under three stall mixes");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0t: %0d expected bytes never arrived", $time, sb.pending());
            $display("tb: failure");
        end
        $finish;
    end
endmodule
